// File: src/swppm_pkg.sv
`timescale 1ns / 1ps
// Package for the single-wire pad poll master: link constants, register
// indexes, phase encoding and the result record. No dependencies.
package swppm_pkg;

  // Link geometry
  localparam int REPLY_BITS   = 64;
  localparam int COMMAND_BITS = 24;
  localparam int TICK_W       = 10;
  localparam int BITC_W       = 7;
  localparam int SEND_W       = 25;
  localparam int CMD_W        = 24;
  localparam int REPLY_W      = 64;
  localparam int PROBE_BITS   = 9;   // eight zero bits plus the stop bit

  // Beat layouts
  localparam int IN_W     = 3;
  localparam int IN_TW    = 8;
  localparam int RES_W    = 68;
  localparam int OUT_TW   = 72;
  localparam int CFG_IDXW = 3;
  localparam int CFG_W    = 24;

  // Masks derived from the link geometry
  localparam logic [CMD_W-1:0] CMD_MASK =
    CMD_W'((25'(1) << COMMAND_BITS) - 25'(1));
  localparam logic [REPLY_W-1:0] REPLY_MASK =
    (REPLY_BITS >= 64) ? {REPLY_W{1'b1}} : REPLY_W'((65'(1) << REPLY_BITS) - 65'(1));

  // Configuration register indexes
  typedef enum logic [CFG_IDXW-1:0] {
    CFG_POLL_COMMAND  = 3'd0,
    CFG_STOP_LEVEL    = 3'd1,
    CFG_SHORT_LOW     = 3'd2,
    CFG_LONG_LOW      = 3'd3,
    CFG_BIT_PERIOD    = 3'd4,
    CFG_SAMPLE_DELAY  = 3'd5,
    CFG_EDGE_TIMEOUT  = 3'd6
  } cfg_idx_t;

  // Transfer phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SEND   = 5'b00010,
    PH_FALL   = 5'b00100,
    PH_SAMPLE = 5'b01000,
    PH_RISE   = 5'b10000
  } phase_t;

  // One result beat, last field in the lowest bits
  typedef struct packed {
    logic [REPLY_W-1:0] reply;
    logic               timed_out;
    logic               done_res;
    logic               busy_res;
    logic               drive_low;
  } res_t;

endpackage

// File: src/single_wire_pad_poll_master_core.sv
`timescale 1ns / 1ps
// Top level of the single-wire pad poll master: per-tick link sequencer,
// result register and skid stage. Depends on swppm_pkg.
//
//  channel   dir  beat holds                                      handshake
//  s_*       in   one clock tick: start_req, mode, line_level     tvalid/tready
//  m_*       out  drive_low, busy_res, done_res, timed_out, reply tvalid/tready
//  cfg_*     in   register write (index, data)                    cfg_we only
//
// One beat in gives one beat out; a beat is accepted in every cycle in which
// s_tready is high, and the sequencer state and the result are registered at
// acceptance, the result into the output register or, if it is held, the skid stage.
// The skid stage takes one beat while m_tready is low, so s_tready stays high until
// it fills; it drops only when both the output register and the skid stage are full.
// rst is synchronous and clears the sequencer, the registers to their
// defaults and the valid flags of both result stages.
module single_wire_pad_poll_master_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // bit 0 start_req, bit 1 mode, bit 2 line_level, rest zero
  input  logic [swppm_pkg::IN_TW-1:0]       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // bit 0 drive_low, 1 busy_res, 2 done_res, 3 timed_out, 67:4 reply, rest zero
  output logic [swppm_pkg::OUT_TW-1:0]      m_tdata,
  input  logic                              cfg_we,
  input  logic [swppm_pkg::CFG_IDXW-1:0]    cfg_index,
  input  logic [swppm_pkg::CFG_W-1:0]       cfg_data
);

  // Configuration registers
  logic [swppm_pkg::CMD_W-1:0]  poll_command;
  logic                         stop_level;
  logic [swppm_pkg::TICK_W-1:0] short_low_ticks;
  logic [swppm_pkg::TICK_W-1:0] long_low_ticks;
  logic [swppm_pkg::TICK_W-1:0] bit_period_ticks;
  logic [swppm_pkg::TICK_W-1:0] sample_delay_ticks;
  logic [swppm_pkg::TICK_W-1:0] edge_timeout_ticks;

  // Sequencer state
  swppm_pkg::phase_t             phase, phase_next;
  logic [swppm_pkg::BITC_W-1:0]  bit_count, bit_count_next;
  logic [swppm_pkg::TICK_W-1:0]  tick_count, tick_count_next;
  logic [swppm_pkg::SEND_W-1:0]  send_shift, send_shift_next;
  logic [swppm_pkg::REPLY_W-1:0] receive_shift, receive_shift_next;
  logic                          active_mode, active_mode_next;

  // Result stages
  swppm_pkg::res_t res, out_reg, skid_reg;
  logic            skid_valid;

  logic in_start, in_mode, in_line;
  logic accept, out_pop;

  assign in_start = s_tdata[0];
  assign in_mode  = s_tdata[1];
  assign in_line  = s_tdata[2];

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_pop  = m_tvalid && m_tready;
  assign m_tdata  = {{(swppm_pkg::OUT_TW - swppm_pkg::RES_W){1'b0}}, out_reg};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_command       <= 24'd4195074;
      stop_level         <= 1'b1;
      short_low_ticks    <= 10'd16;
      long_low_ticks     <= 10'd48;
      bit_period_ticks   <= 10'd64;
      sample_delay_ticks <= 10'd32;
      edge_timeout_ticks <= 10'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        swppm_pkg::CFG_POLL_COMMAND: poll_command       <= cfg_data;
        swppm_pkg::CFG_STOP_LEVEL:   stop_level         <= cfg_data[0];
        swppm_pkg::CFG_SHORT_LOW:    short_low_ticks    <= cfg_data[swppm_pkg::TICK_W-1:0];
        swppm_pkg::CFG_LONG_LOW:     long_low_ticks     <= cfg_data[swppm_pkg::TICK_W-1:0];
        swppm_pkg::CFG_BIT_PERIOD:   bit_period_ticks   <= cfg_data[swppm_pkg::TICK_W-1:0];
        swppm_pkg::CFG_SAMPLE_DELAY: sample_delay_ticks <= cfg_data[swppm_pkg::TICK_W-1:0];
        swppm_pkg::CFG_EDGE_TIMEOUT: edge_timeout_ticks <= cfg_data[swppm_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // One tick of the link sequencer
  always_comb begin
    logic [swppm_pkg::TICK_W-1:0] tc_inc;
    logic [swppm_pkg::TICK_W-1:0] low_len;
    logic [swppm_pkg::SEND_W-1:0] shifted;
    logic [swppm_pkg::BITC_W-1:0] bc_dec;
    logic                         tx_bit;
    logic                         drive, done, tmo;

    phase_next         = phase;
    bit_count_next     = bit_count;
    tick_count_next    = tick_count;
    send_shift_next    = send_shift;
    receive_shift_next = receive_shift;
    active_mode_next   = active_mode;
    drive = 1'b0;
    done  = 1'b0;
    tmo   = 1'b0;

    // start in idle loads the transfer; this tick is tick zero of bit one
    if (phase == swppm_pkg::PH_IDLE && in_start) begin
      active_mode_next = in_mode;
      tick_count_next  = '0;
      if (!in_mode) begin
        send_shift_next    = {poll_command & swppm_pkg::CMD_MASK, stop_level};
        bit_count_next     = swppm_pkg::BITC_W'(swppm_pkg::COMMAND_BITS + 1);
        receive_shift_next = '0;
      end else begin
        send_shift_next = {{(swppm_pkg::SEND_W-1){1'b0}}, stop_level};
        bit_count_next  = swppm_pkg::BITC_W'(swppm_pkg::PROBE_BITS);
      end
      phase_next = swppm_pkg::PH_SEND;
    end

    tc_inc  = tick_count_next + 10'd1;
    bc_dec  = (bit_count_next == '0) ? '0 : bit_count_next - 7'd1;
    shifted = send_shift_next >> bc_dec[4:0];
    tx_bit  = (bit_count_next != '0) && shifted[0];
    low_len = tx_bit ? short_low_ticks : long_low_ticks;

    unique case (phase_next)
      swppm_pkg::PH_SEND: begin
        drive = (tick_count_next < low_len);
        tick_count_next = tc_inc;
        if (tc_inc >= bit_period_ticks || bit_period_ticks <= 10'd1) begin
          tick_count_next = '0;
          bit_count_next  = bc_dec;
          if (bc_dec == '0) begin
            if (active_mode_next) begin
              phase_next = swppm_pkg::PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next     = swppm_pkg::PH_FALL;
              bit_count_next = swppm_pkg::BITC_W'(swppm_pkg::REPLY_BITS);
            end
          end
        end
      end
      swppm_pkg::PH_FALL: begin
        if (!in_line) begin
          phase_next      = swppm_pkg::PH_SAMPLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_inc;
          if (tc_inc >= edge_timeout_ticks) begin
            phase_next      = swppm_pkg::PH_IDLE;
            tick_count_next = '0;
            done            = 1'b1;
            tmo             = 1'b1;
          end
        end
      end
      swppm_pkg::PH_SAMPLE: begin
        tick_count_next = tc_inc;
        if (tc_inc >= sample_delay_ticks) begin
          receive_shift_next = {receive_shift_next[swppm_pkg::REPLY_W-2:0], in_line}
                               & swppm_pkg::REPLY_MASK;
          phase_next         = swppm_pkg::PH_RISE;
          tick_count_next    = '0;
        end
      end
      swppm_pkg::PH_RISE: begin
        if (in_line) begin
          tick_count_next = '0;
          bit_count_next  = bc_dec;
          if (bc_dec == '0) begin
            phase_next = swppm_pkg::PH_IDLE;
            done       = 1'b1;
          end else begin
            phase_next = swppm_pkg::PH_FALL;
          end
        end else begin
          tick_count_next = tc_inc;
          if (tc_inc >= edge_timeout_ticks) begin
            phase_next      = swppm_pkg::PH_IDLE;
            tick_count_next = '0;
            done            = 1'b1;
            tmo             = 1'b1;
          end
        end
      end
      swppm_pkg::PH_IDLE: ;
      default: phase_next = swppm_pkg::PH_IDLE;
    endcase

    res.drive_low = drive;
    res.busy_res  = (phase_next != swppm_pkg::PH_IDLE);
    res.done_res  = done;
    res.timed_out = tmo;
    res.reply     = receive_shift_next;
  end

  // Sequencer state advances once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= swppm_pkg::PH_IDLE;
      bit_count     <= '0;
      tick_count    <= '0;
      send_shift    <= '0;
      receive_shift <= '0;
      active_mode   <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      tick_count    <= tick_count_next;
      send_shift    <= send_shift_next;
      receive_shift <= receive_shift_next;
      active_mode   <= active_mode_next;
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!m_tvalid || out_pop) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (!m_tvalid || out_pop) begin
        out_reg <= res;
      end else begin
        skid_reg <= res;
      end
    end
  end

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid stage holds a beat while the output register is empty");

  a_tmo_with_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!out_reg.timed_out || out_reg.done_res))
    else $error("timeout flagged without end of transfer");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_reg.done_res && out_reg.busy_res))
    else $error("end of transfer reported while still busy");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    (accept && res.done_res) |=> (phase == swppm_pkg::PH_IDLE))
    else $error("sequencer not idle after end of transfer");

endmodule
